// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/tga_pkg.sv
// Shared types for the Targa pixel stream decoder.
`timescale 1ns / 1ps

package tga_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_RLE_ENABLE   = 2'd0,
    CFG_PIXEL_BITS   = 2'd1,
    CFG_GRAY_MODE    = 2'd2,
    CFG_ALPHA_ENABLE = 2'd3
  } tga_cfg_idx_e;

  // Width of the configuration write data.
  localparam int unsigned CfgDataW = 8;

  // Converted color of one pixel.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       depth_error;
  } tga_color_t;

endpackage

// File: rtl/core/tga_if.sv
// Valid/ready channel interfaces of the decoder: byte input, pixel output, config writes.
`timescale 1ns / 1ps

interface tga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface tga_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] run_length;
  logic       depth_error;

  modport source (output valid, output alpha_out, output red_out, output green_out,
                  output blue_out, output run_length, output depth_error, input ready);
  modport sink   (input valid, input alpha_out, input red_out, input green_out,
                  input blue_out, input run_length, input depth_error, output ready);
endinterface

interface tga_cfg_if;
  logic                           valid;
  logic                           ready;
  tga_pkg::tga_cfg_idx_e          index;
  logic [tga_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/tga_color_conv.sv
// Combinational conversion of one assembled pixel word into ARGB or gray output.
`timescale 1ns / 1ps

module tga_color_conv (
  input  logic [31:0]         pixel_i,
  input  logic [5:0]          pixel_bits_i,
  input  logic                gray_mode_i,
  input  logic                alpha_enable_i,
  output tga_pkg::tga_color_t color_o
);
  import tga_pkg::*;

  // Supported true-color depths.
  localparam logic [5:0] Depth15 = 6'd15;
  localparam logic [5:0] Depth16 = 6'd16;
  localparam logic [5:0] Depth24 = 6'd24;
  localparam logic [5:0] Depth32 = 6'd32;

  // Widens a 5-bit channel to 8 bits.
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [7:0] w;
    case (c)
      5'd0:  w = 8'd0;    5'd1:  w = 8'd8;    5'd2:  w = 8'd16;   5'd3:  w = 8'd25;
      5'd4:  w = 8'd33;   5'd5:  w = 8'd41;   5'd6:  w = 8'd49;   5'd7:  w = 8'd58;
      5'd8:  w = 8'd66;   5'd9:  w = 8'd74;   5'd10: w = 8'd82;   5'd11: w = 8'd90;
      5'd12: w = 8'd99;   5'd13: w = 8'd107;  5'd14: w = 8'd115;  5'd15: w = 8'd123;
      5'd16: w = 8'd132;  5'd17: w = 8'd140;  5'd18: w = 8'd148;  5'd19: w = 8'd156;
      5'd20: w = 8'd165;  5'd21: w = 8'd173;  5'd22: w = 8'd181;  5'd23: w = 8'd189;
      5'd24: w = 8'd197;  5'd25: w = 8'd206;  5'd26: w = 8'd214;  5'd27: w = 8'd222;
      5'd28: w = 8'd230;  5'd29: w = 8'd239;  5'd30: w = 8'd247;  default: w = 8'd255;
    endcase
    return w;
  endfunction

  // Computes c*a/255 rounded down; the add-and-shift form is exact for products below 65535.
  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = c * a;
    sum  = {1'b0, prod} + {9'b0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // Channel extraction by mode and depth, then optional alpha premultiply of true-color pixels.
  always_comb begin
    color_o = '0;
    color_o.alpha = 8'hff;
    if (gray_mode_i) begin
      color_o.red = pixel_i[7:0];
      if (alpha_enable_i) begin
        color_o.alpha = pixel_i[15:8];
      end
    end else begin
      case (pixel_bits_i)
        Depth32: begin
          color_o.alpha = pixel_i[31:24];
          color_o.red   = pixel_i[23:16];
          color_o.green = pixel_i[15:8];
          color_o.blue  = pixel_i[7:0];
        end
        Depth24: begin
          color_o.red   = pixel_i[23:16];
          color_o.green = pixel_i[15:8];
          color_o.blue  = pixel_i[7:0];
        end
        Depth16, Depth15: begin
          if (pixel_bits_i == Depth16) begin
            color_o.alpha = pixel_i[15] ? 8'hff : 8'h00;
          end
          color_o.red   = widen5(pixel_i[14:10]);
          color_o.green = widen5(pixel_i[9:5]);
          color_o.blue  = widen5(pixel_i[4:0]);
        end
        default: begin
          color_o.depth_error = 1'b1;
          color_o.alpha       = 8'h00;
        end
      endcase
      if (!color_o.depth_error) begin
        if (alpha_enable_i) begin
          if (color_o.alpha != 8'h00 && color_o.alpha != 8'hff) begin
            color_o.red   = scale_chan(color_o.red, color_o.alpha);
            color_o.green = scale_chan(color_o.green, color_o.alpha);
            color_o.blue  = scale_chan(color_o.blue, color_o.alpha);
          end
        end else begin
          color_o.alpha = 8'hff;
        end
      end
    end
  end

endmodule

// File: rtl/core/tga_rle_pixel_decoder.sv
// Top level of the Targa run-length pixel stream decoder.
`timescale 1ns / 1ps

// The decoder takes image data one byte per beat on in_i and returns one pixel
// beat on out_o for each completed pixel, carrying ARGB (or gray plus alpha),
// a run length and a depth error flag. Header bytes of run-length packets and
// bytes that do not complete a pixel give no output beat.
// Configuration is written on cfg_i, one register per beat, and is always
// taken; write it only while no pixel is pending on the output.
// Throughput: one byte per clock cycle, sustained until a stall on out_o has
// filled both stages. A pixel's assembled word is registered in the pixel stage
// when its last byte is accepted, and its converted color is then loaded into
// the output register.
// When out_o stalls, the output register holds its beat and the pixel stage
// behind it still fills, so in_i keeps accepting bytes until both are full.
// Reset clears the packet state to expect a header, empties both stages and
// loads the register defaults: RLE off, 24-bit pixels, true color, no alpha.
module tga_rle_pixel_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  tga_cfg_if.sink         cfg_i,
  tga_byte_if.sink        in_i,
  tga_pix_if.source       out_o
);
  import tga_pkg::*;

  // Configuration registers.
  logic       rle_en_q, gray_q, alpha_en_q;
  logic [5:0] pixel_bits_q;

  // Packet and byte assembly state.
  logic       expect_hdr_q, expect_hdr_d;
  logic       in_rep_q, in_rep_d;
  logic [6:0] repeat_cnt_q, repeat_cnt_d;
  logic [6:0] raw_left_q, raw_left_d;
  logic [1:0] byte_idx_q, byte_idx_d;
  logic [23:0] accum_q, accum_d;

  // Pixel stage and output stage.
  logic        pix_valid_q, pix_valid_d;
  logic [31:0] pix_word_q;
  logic [7:0]  pix_run_q;
  logic        out_valid_q, out_valid_d;
  tga_color_t  out_color_q;
  logic [7:0]  out_run_q;

  logic        in_fire, pix_ready, emit;
  logic [31:0] word_asm;
  logic [7:0]  run_asm;
  logic [3:0]  bytes_raw;
  logic [1:0]  last_idx;
  tga_color_t  color;

  // Configuration writes are always accepted.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_en_q     <= 1'b0;
      pixel_bits_q <= 6'd24;
      gray_q       <= 1'b0;
      alpha_en_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RLE_ENABLE:   rle_en_q     <= cfg_i.data[0];
        CFG_PIXEL_BITS:   pixel_bits_q <= cfg_i.data[5:0];
        CFG_GRAY_MODE:    gray_q       <= cfg_i.data[0];
        CFG_ALPHA_ENABLE: alpha_en_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Handshake chain: the output register frees the pixel stage, which frees the input.
  assign pix_ready  = !out_valid_q || out_o.ready;
  assign in_i.ready = !pix_valid_q || pix_ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Index of the last byte of a pixel, from the depth rounded up and clamped to 1..4 bytes.
  assign bytes_raw = 4'(({1'b0, pixel_bits_q} + 7'd7) >> 3);
  always_comb begin
    if (bytes_raw == 4'd0) begin
      last_idx = 2'd0;
    end else if (bytes_raw > 4'd4) begin
      last_idx = 2'd3;
    end else begin
      last_idx = 2'(bytes_raw - 4'd1);
    end
  end

  // Packet header decode and little-endian byte assembly.
  always_comb begin
    expect_hdr_d = expect_hdr_q;
    in_rep_d     = in_rep_q;
    repeat_cnt_d = repeat_cnt_q;
    raw_left_d   = raw_left_q;
    byte_idx_d   = byte_idx_q;
    accum_d      = accum_q;
    emit         = 1'b0;
    run_asm      = 8'd1;
    word_asm     = (byte_idx_q == 2'd0) ? 32'd0 : {8'd0, accum_q};
    word_asm[{byte_idx_q, 3'b000} +: 8] = in_i.byte_in;
    if (in_fire) begin
      if (rle_en_q && expect_hdr_q) begin
        in_rep_d     = in_i.byte_in[7];
        repeat_cnt_d = in_i.byte_in[7] ? in_i.byte_in[6:0] : 7'd0;
        raw_left_d   = in_i.byte_in[7] ? 7'd0 : in_i.byte_in[6:0];
        expect_hdr_d = 1'b0;
        byte_idx_d   = 2'd0;
        accum_d      = '0;
      end else if (byte_idx_q < last_idx) begin
        accum_d    = word_asm[23:0];
        byte_idx_d = byte_idx_q + 2'd1;
      end else begin
        emit       = 1'b1;
        byte_idx_d = 2'd0;
        if (rle_en_q) begin
          if (in_rep_q) begin
            run_asm      = {1'b0, repeat_cnt_q} + 8'd1;
            expect_hdr_d = 1'b1;
          end else if (raw_left_q == 7'd0) begin
            expect_hdr_d = 1'b1;
          end else begin
            raw_left_d = raw_left_q - 7'd1;
          end
        end
      end
    end
  end

  // Stage valid flags.
  always_comb begin
    pix_valid_d = pix_valid_q;
    if (pix_valid_q && pix_ready) begin
      pix_valid_d = 1'b0;
    end
    if (emit) begin
      pix_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (pix_ready) begin
      out_valid_d = pix_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
      in_rep_q     <= 1'b0;
      repeat_cnt_q <= 7'd0;
      raw_left_q   <= 7'd0;
      byte_idx_q   <= 2'd0;
      pix_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      expect_hdr_q <= expect_hdr_d;
      in_rep_q     <= in_rep_d;
      repeat_cnt_q <= repeat_cnt_d;
      raw_left_q   <= raw_left_d;
      byte_idx_q   <= byte_idx_d;
      pix_valid_q  <= pix_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    accum_q <= accum_d;
    if (emit) begin
      pix_word_q <= word_asm;
      pix_run_q  <= run_asm;
    end
    if (pix_ready && pix_valid_q) begin
      out_color_q <= color;
      out_run_q   <= pix_run_q;
    end
  end

  // Color conversion between the pixel stage and the output register.
  tga_color_conv u_color_conv (
    .pixel_i        (pix_word_q),
    .pixel_bits_i   (pixel_bits_q),
    .gray_mode_i    (gray_q),
    .alpha_enable_i (alpha_en_q),
    .color_o        (color)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.alpha_out   = out_color_q.alpha;
  assign out_o.red_out     = out_color_q.red;
  assign out_o.green_out   = out_color_q.green;
  assign out_o.blue_out    = out_color_q.blue;
  assign out_o.run_length  = out_run_q;
  assign out_o.depth_error = out_color_q.depth_error;

endmodule

// File: rtl/core/tga_rle_pixel_decoder_chk.sv
// Port-level checker for the Targa pixel stream decoder and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tga_rle_pixel_decoder_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] alpha_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] run_i,
  input logic       err_i
);

  // Handshake terms and the flattened output beat.
  logic        in_beat;
  logic        out_stall;
  logic        out_blank;
  logic [40:0] out_beat;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_beat  = {alpha_i, red_i, green_i, blue_i, run_i, err_i};
  assign out_blank = (alpha_i == 8'd0) && (red_i == 8'd0) &&
                     (green_i == 8'd0) && (blue_i == 8'd0);

  // A stalled output beat stays valid and unchanged.
  `ASSERT_NEXT(out_hold_a, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_beat))

  // The input only backs up when the output is full and stalled.
  `ASSERT_IMPLIES(in_stall_a, clk_i, rst_ni, !in_ready_i, out_stall)

  // A new output beat follows an accepted byte, by way of the pixel stage.
  `ASSERT_IMPLIES(out_latency_a, clk_i, rst_ni, $rose(out_valid_i), $past(in_beat, 2))

  // An unsupported depth gives a blank pixel.
  `ASSERT_IMPLIES(err_blank_a, clk_i, rst_ni, out_valid_i && err_i, out_blank)

endmodule

bind tga_rle_pixel_decoder tga_rle_pixel_decoder_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .alpha_i     (out_o.alpha_out),
  .red_i       (out_o.red_out),
  .green_i     (out_o.green_out),
  .blue_i      (out_o.blue_out),
  .run_i       (out_o.run_length),
  .err_i       (out_o.depth_error)
);
